[design/swdd_pkg.sv]
// ----------------------------------------------------------------------------
// Swing-damping door detector package
// Types and constants shared by the door detector modules.
// ----------------------------------------------------------------------------
package swdd_pkg;

    localparam int PITCH_W  = 17;
    localparam int RATE_W   = 24;
    localparam int LIMIT_W  = 16;
    localparam int THRESH_W = 23;
    localparam int SIZE_W   = 23;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;

    localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWING_THR   = 2'd2;

    localparam logic [LIMIT_W-1:0]  OPEN_LIMIT_RST  = 16'd1024;
    localparam logic [LIMIT_W-1:0]  CLOSE_LIMIT_RST = 16'd307;
    localparam logic [THRESH_W-1:0] SWING_THR_RST   = 23'd128;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_PEAK   = 2'd1,
        KIND_TROUGH = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_NOT_READY = 2'd0,
        ST_DETECTING = 2'd1,
        ST_OPEN      = 2'd2,
        ST_CLOSED    = 2'd3
    } t_status;

    typedef struct packed {
        logic [LIMIT_W-1:0]  open_limit;
        logic [LIMIT_W-1:0]  close_limit;
        logic [THRESH_W-1:0] swing_thr;
    } t_cfg;

    typedef struct packed {
        logic                      fusion_ready;
        logic signed [PITCH_W-1:0] pitch_angle;
        logic signed [RATE_W-1:0]  rate_x;
        logic                      gyro_moving;
        logic                      accel_moving;
    } t_sample;

endpackage

[design/swdd_tracker.sv]
// ----------------------------------------------------------------------------
// Swing tracker
// Follows the rate direction, merges peaks and troughs, counts swings and
// damped swings, and decides the door status of each accepted sample.
// ----------------------------------------------------------------------------
module swdd_tracker
    import swdd_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  t_sample i_sample,
    input  t_cfg    i_cfg,
    output t_status o_status
);

    logic signed [RATE_W-1:0] r_last_rate, n_last_rate;
    logic                     r_rising, n_rising;
    logic                     r_started, n_started;
    t_kind                    r_last_kind, n_last_kind;
    t_kind                    r_earlier_kind, n_earlier_kind;
    logic [SIZE_W-1:0]        r_last_size, n_last_size;
    logic [SIZE_W-1:0]        r_earlier_size, n_earlier_size;
    logic [COUNT_WIDTH-1:0]   r_swing_cnt, n_swing_cnt;
    logic [COUNT_WIDTH-1:0]   r_damped_cnt, n_damped_cnt;
    t_status                  r_held, n_held;

    logic [PITCH_W-1:0]       pitch_mag;
    logic                     is_open;
    logic                     dir_new;
    logic signed [RATE_W:0]   last_ext;
    logic signed [RATE_W:0]   thr_ext;
    logic [RATE_W:0]          neg_last;
    logic                     peak_hit;
    logic                     trough_hit;
    t_kind                    ext_kind;
    t_kind                    other_kind;
    logic [SIZE_W-1:0]        ext_size;
    logic                     earlier_valid;
    t_status                  status;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    assign pitch_mag = i_sample.pitch_angle[PITCH_W-1]
                     ? (~i_sample.pitch_angle + 1'b1)
                     : i_sample.pitch_angle;
    assign is_open = pitch_mag >= {1'b0, i_cfg.open_limit};

    // Equal rates keep the previous direction.
    assign dir_new = (i_sample.rate_x > r_last_rate) ? 1'b1
                   : (i_sample.rate_x < r_last_rate) ? 1'b0 : r_rising;

    assign last_ext = {r_last_rate[RATE_W-1], r_last_rate};
    assign thr_ext  = $signed({2'b00, i_cfg.swing_thr});
    assign neg_last = -last_ext;

    assign peak_hit   = r_rising && !dir_new && (last_ext > thr_ext);
    assign trough_hit = !r_rising && dir_new && (last_ext <= -thr_ext);

    assign ext_kind   = peak_hit ? KIND_PEAK : KIND_TROUGH;
    assign other_kind = peak_hit ? KIND_TROUGH : KIND_PEAK;
    // Only the most negative rate overflows the trough magnitude.
    assign ext_size   = peak_hit ? r_last_rate[SIZE_W-1:0]
                      : (neg_last > (RATE_W+1)'(SIZE_MAX)) ? SIZE_MAX
                      : neg_last[SIZE_W-1:0];
    assign earlier_valid = (r_earlier_kind == KIND_PEAK) || (r_earlier_kind == KIND_TROUGH);

    always_comb begin
        n_last_rate    = r_last_rate;
        n_rising       = r_rising;
        n_started      = r_started;
        n_last_kind    = r_last_kind;
        n_earlier_kind = r_earlier_kind;
        n_last_size    = r_last_size;
        n_earlier_size = r_earlier_size;
        n_swing_cnt    = r_swing_cnt;
        n_damped_cnt   = r_damped_cnt;
        n_held         = r_held;
        status         = ST_NOT_READY;

        if (i_sample.fusion_ready) begin
            n_last_rate = i_sample.rate_x;
            if (is_open) begin
                n_started      = 1'b0;
                n_last_kind    = KIND_NONE;
                n_earlier_kind = KIND_NONE;
                n_last_size    = '0;
                n_earlier_size = '0;
                n_swing_cnt    = '0;
                n_damped_cnt   = '0;
                status         = ST_OPEN;
            end else begin
                n_rising = dir_new;
                if (r_started) begin
                    if (peak_hit || trough_hit) begin
                        if (r_last_kind == ext_kind) begin
                            if (ext_size > r_last_size) begin
                                n_last_size = ext_size;
                            end
                        end else if (r_last_kind == other_kind) begin
                            if (earlier_valid) begin
                                if (r_last_size <= r_earlier_size && r_damped_cnt != CNT_MAX) begin
                                    n_damped_cnt = r_damped_cnt + 1'b1;
                                end
                                if (r_swing_cnt != CNT_MAX) begin
                                    n_swing_cnt = r_swing_cnt + 1'b1;
                                end
                            end
                            n_earlier_kind = r_last_kind;
                            n_earlier_size = r_last_size;
                            n_last_kind    = ext_kind;
                            n_last_size    = ext_size;
                        end else begin
                            n_last_kind = ext_kind;
                            n_last_size = ext_size;
                        end
                    end
                    if (!i_sample.gyro_moving && !i_sample.accel_moving) begin
                        if (n_damped_cnt >= (n_swing_cnt >> 1)
                                && pitch_mag < {1'b0, i_cfg.close_limit}) begin
                            n_held = ST_CLOSED;
                        end else begin
                            n_held = ST_OPEN;
                        end
                    end
                end else begin
                    n_started = 1'b1;
                    n_held    = ST_DETECTING;
                end
                status = n_held;
            end
        end
    end

    assign o_status = status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_rate    <= '0;
            r_rising       <= 1'b0;
            r_started      <= 1'b0;
            r_last_kind    <= KIND_NONE;
            r_earlier_kind <= KIND_NONE;
            r_last_size    <= '0;
            r_earlier_size <= '0;
            r_swing_cnt    <= '0;
            r_damped_cnt   <= '0;
            r_held         <= ST_DETECTING;
        end else if (i_accept) begin
            r_last_rate    <= n_last_rate;
            r_rising       <= n_rising;
            r_started      <= n_started;
            r_last_kind    <= n_last_kind;
            r_earlier_kind <= n_earlier_kind;
            r_last_size    <= n_last_size;
            r_earlier_size <= n_earlier_size;
            r_swing_cnt    <= n_swing_cnt;
            r_damped_cnt   <= n_damped_cnt;
            r_held         <= n_held;
        end
    end

`ifndef SYNTHESIS
    // A damped swing is always counted as a swing as well.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_damped_cnt <= r_swing_cnt)
        else $error("damped count exceeds swing count");

    // Without tracking there are no swings.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_started |-> (r_swing_cnt == '0 && r_last_kind == KIND_NONE))
        else $error("swing state present while tracking is stopped");

    // An older extreme only exists once a newer one has been seen.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_last_kind == KIND_NONE) |-> (r_earlier_kind == KIND_NONE))
        else $error("older extreme held without a newer one");
`endif

endmodule

[design/swdd_out_reg.sv]
// ----------------------------------------------------------------------------
// Result register
// Holds one door status until the downstream side takes it.
// ----------------------------------------------------------------------------
module swdd_out_reg
    import swdd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_status i_status,
    input  logic    i_taken,
    output logic    o_valid,
    output t_status o_status
);

    logic    r_valid;
    t_status r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_taken) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_status <= i_status;
        end
    end

    assign o_valid  = r_valid;
    assign o_status = r_status;

endmodule

[design/swing_damping_door_detector.sv]
// A result appears on the master side in the cycle after its sample is taken.
// Throughput: one sample per cycle while results are taken; the single result
// register is refilled in the same cycle in which its previous status is taken.
// Reset: synchronous, active low; limits return to 1024, 307 and 128, tracking
// is cleared and the held status is detecting. No clearing pass is needed.
// ----------------------------------------------------------------------------
// Swing-damping door detector
// Classifies each sample as not ready, detecting, open or closed from pitch
// and the damping of rotation-rate swings.
// ----------------------------------------------------------------------------
module swing_damping_door_detector
    import swdd_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [16:0] pitch_angle, [40:17] rate_x, [41] gyro_moving, [42] accel_moving
    input  logic [47:0]           s_axis_tdata,
    // [0] fusion_ready
    input  logic [0:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [1:0] door_code
    output logic [7:0]            m_axis_tdata
);

    t_cfg    r_cfg;
    t_sample sample;
    t_status next_status;
    t_status held_out;
    logic    accept;
    logic    out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.open_limit  <= OPEN_LIMIT_RST;
            r_cfg.close_limit <= CLOSE_LIMIT_RST;
            r_cfg.swing_thr   <= SWING_THR_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_OPEN_LIMIT:  r_cfg.open_limit  <= i_cfg_data[LIMIT_W-1:0];
                CFG_CLOSE_LIMIT: r_cfg.close_limit <= i_cfg_data[LIMIT_W-1:0];
                CFG_SWING_THR:   r_cfg.swing_thr   <= i_cfg_data[THRESH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign sample.fusion_ready = s_axis_tuser[0];
    assign sample.pitch_angle  = s_axis_tdata[16:0];
    assign sample.rate_x       = s_axis_tdata[40:17];
    assign sample.gyro_moving  = s_axis_tdata[41];
    assign sample.accel_moving = s_axis_tdata[42];

    // A new transaction is taken whenever the result register is empty or
    // is being emptied in this cycle.
    assign s_axis_tready = !out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    swdd_tracker #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_sample (sample),
        .i_cfg    (r_cfg),
        .o_status (next_status)
    );

    swdd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (accept),
        .i_status (next_status),
        .i_taken  (m_axis_tready),
        .o_valid  (out_valid),
        .o_status (held_out)
    );

    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {6'b0, held_out};

`ifndef SYNTHESIS
    // A sample without valid orientation data always reports not ready.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !s_axis_tuser[0]) |=>
        (m_axis_tvalid && m_axis_tdata[1:0] == ST_NOT_READY))
        else $error("unready sample did not report not ready");

    // A valid sample never reports not ready.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s_axis_tuser[0]) |=>
        (m_axis_tvalid && m_axis_tdata[1:0] != ST_NOT_READY))
        else $error("ready sample reported not ready");

    // Input is only held off while a result waits to be taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without a pending result");
`endif

endmodule
